FILE: rtl/mm_pkg.sv
package mm_pkg;

    // Fixed port widths.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 4;
    localparam int POS_W      = 3;
    localparam int WORD_W     = 32;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS_LEFT  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INNER_DIM  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COLS_RIGHT = 2'd2;

    localparam logic [CFG_DATA_W-1:0] DIM_RESET = 4'd8;

    // Operand select of an input word.
    localparam logic FUNC_LEFT = 1'b0;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_MUL_LO,
        ST_MUL_HI,
        ST_ADD_HI,
        ST_ROUND,
        ST_EMIT
    } mm_state_t;

endpackage

FILE: rtl/matrix_multiply_top.sv
// Load words are taken one per cycle while in_stall is low; a word with start_product stores its element and
// then holds in_stall high until the last product word has been issued.
// Each product element takes, per term, one memory read and two half-width multiply passes
// through the single shared multiplier and accumulator adder, then a rounding and an emit step.
// A full product emits rows_left * cols_right elements in turn; out_stall holds the emit step.
// Reset clears the sequencer and output valid and sets all dimensions to 8; stores are not cleared.
module matrix_multiply_top #(
    parameter int MAX_DIM    = 8,
    parameter int VALUE_BITS = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,

    input  logic                            cfg_wr_en,
    input  logic [mm_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [mm_pkg::CFG_DATA_W-1:0]   cfg_data,

    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic                            func,
    input  logic [mm_pkg::POS_W-1:0]        elem_row,
    input  logic [mm_pkg::POS_W-1:0]        elem_col,
    input  logic signed [mm_pkg::WORD_W-1:0] elem_value,
    input  logic                            start_product,

    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [mm_pkg::POS_W-1:0]        out_row,
    output logic [mm_pkg::POS_W-1:0]        out_col,
    output logic signed [mm_pkg::WORD_W-1:0] out_value,
    output logic                            saturated,
    output logic                            last_result
);

    localparam int IDX_W   = $clog2(MAX_DIM);
    localparam int ADDR_W  = 2 * IDX_W;
    localparam int DEPTH   = 1 << ADDR_W;
    localparam int IN_BITS = (VALUE_BITS < mm_pkg::WORD_W) ? VALUE_BITS : mm_pkg::WORD_W;
    localparam int HB      = VALUE_BITS / 2;
    localparam int MB      = VALUE_BITS - HB + 1;
    localparam int PROD_W  = VALUE_BITS + MB;
    localparam int ACC_W   = 2 * VALUE_BITS + $clog2(MAX_DIM) + 1;
    localparam logic [ACC_W-1:0] HALF = ({{(ACC_W-1){1'b0}}, 1'b1} << FRAC_BITS) >> 1;
    localparam logic [mm_pkg::CFG_DATA_W-1:0] MAX_DIM_C = mm_pkg::CFG_DATA_W'(MAX_DIM);

    function automatic logic [IDX_W-1:0] last_index(input logic [mm_pkg::CFG_DATA_W-1:0] d);
        logic [IDX_W-1:0] r;
        if (d == '0)
        begin
            r = '0;
        end
        else if (d > MAX_DIM_C)
        begin
            r = IDX_W'(MAX_DIM - 1);
        end
        else
        begin
            r = IDX_W'(d - 1'b1);
        end
        return r;
    endfunction

    // Configuration.
    logic [mm_pkg::CFG_DATA_W-1:0] rows_left_reg;
    logic [mm_pkg::CFG_DATA_W-1:0] inner_dim_reg;
    logic [mm_pkg::CFG_DATA_W-1:0] cols_right_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_left_reg  <= mm_pkg::DIM_RESET;
            inner_dim_reg  <= mm_pkg::DIM_RESET;
            cols_right_reg <= mm_pkg::DIM_RESET;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                mm_pkg::CFG_ROWS_LEFT:  rows_left_reg  <= cfg_data;
                mm_pkg::CFG_INNER_DIM:  inner_dim_reg  <= cfg_data;
                mm_pkg::CFG_COLS_RIGHT: cols_right_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    logic [IDX_W-1:0] m_last;
    logic [IDX_W-1:0] n_last;
    logic [IDX_W-1:0] o_last;

    assign m_last = last_index(rows_left_reg);
    assign n_last = last_index(inner_dim_reg);
    assign o_last = last_index(cols_right_reg);

    // Registers.
    mm_pkg::mm_state_t state_reg, state_next;
    logic [IDX_W-1:0]          i_reg, i_next;
    logic [IDX_W-1:0]          j_reg, j_next;
    logic [IDX_W-1:0]          k_reg, k_next;
    logic signed [ACC_W-1:0]   acc_reg, acc_next;
    logic signed [PROD_W-1:0]  prod_reg, prod_next;
    logic                      out_valid_reg, out_valid_next;
    logic [mm_pkg::POS_W-1:0]  out_row_reg, out_row_next;
    logic [mm_pkg::POS_W-1:0]  out_col_reg, out_col_next;
    logic signed [mm_pkg::WORD_W-1:0] out_value_reg, out_value_next;
    logic                      saturated_reg, saturated_next;
    logic                      last_result_reg, last_result_next;

    logic in_accept;
    logic in_range;

    assign in_stall  = (state_reg != mm_pkg::ST_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign in_range  = ({1'b0, elem_row} < 4'(MAX_DIM)) && ({1'b0, elem_col} < 4'(MAX_DIM));

    // Operand stores.
    logic signed [VALUE_BITS-1:0] left_mem  [0:DEPTH-1];
    logic signed [VALUE_BITS-1:0] right_mem [0:DEPTH-1];
    logic signed [VALUE_BITS-1:0] left_rd_reg;
    logic signed [VALUE_BITS-1:0] right_rd_reg;
    logic signed [VALUE_BITS-1:0] wr_value;
    logic [ADDR_W-1:0]            wr_addr;

    assign wr_value = VALUE_BITS'($signed(elem_value[IN_BITS-1:0]));
    assign wr_addr  = {elem_row[IDX_W-1:0], elem_col[IDX_W-1:0]};

    always_ff @(posedge clk)
    begin
        if (in_accept && in_range && (func == mm_pkg::FUNC_LEFT))
        begin
            left_mem[wr_addr] <= wr_value;
        end
        if (in_accept && in_range && (func != mm_pkg::FUNC_LEFT))
        begin
            right_mem[wr_addr] <= wr_value;
        end
        left_rd_reg  <= left_mem[{i_reg, k_reg}];
        right_rd_reg <= right_mem[{k_reg, j_reg}];
    end

    // Shared multiplier: the right operand goes in as a low unsigned half, then a signed high half.
    logic signed [MB-1:0]     b_op;
    logic signed [PROD_W-1:0] mul_res;

    always_comb
    begin
        if (state_reg == mm_pkg::ST_MUL_HI)
        begin
            b_op = MB'($signed(right_rd_reg[VALUE_BITS-1:HB]));
        end
        else
        begin
            b_op = $signed(MB'(right_rd_reg[HB-1:0]));
        end
    end

    assign mul_res = left_rd_reg * b_op;

    // Shared accumulator adder.
    logic signed [ACC_W-1:0] addend;
    logic signed [ACC_W-1:0] acc_sum;

    always_comb
    begin
        case (state_reg)
            mm_pkg::ST_MUL_HI: addend = ACC_W'(prod_reg);
            mm_pkg::ST_ADD_HI: addend = ACC_W'(prod_reg) <<< HB;
            mm_pkg::ST_ROUND:  addend = $signed(HALF);
            default:           addend = '0;
        endcase
    end

    assign acc_sum = acc_reg + addend;

    // Rounding shift and saturation of the finished dot product.
    logic signed [ACC_W-1:0]      shifted;
    logic                         fits;
    logic signed [VALUE_BITS-1:0] res_val;

    assign shifted = acc_reg >>> FRAC_BITS;
    assign fits    = (shifted[ACC_W-1:VALUE_BITS-1] == '0) ||
                     (shifted[ACC_W-1:VALUE_BITS-1] == '1);

    always_comb
    begin
        if (fits)
        begin
            res_val = shifted[VALUE_BITS-1:0];
        end
        else if (shifted[ACC_W-1])
        begin
            res_val = {1'b1, {(VALUE_BITS-1){1'b0}}};
        end
        else
        begin
            res_val = {1'b0, {(VALUE_BITS-1){1'b1}}};
        end
    end

    logic emit_ok;
    logic last_elem;

    assign emit_ok   = !out_valid_reg || !out_stall;
    assign last_elem = (i_reg == m_last) && (j_reg == o_last);

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            mm_pkg::ST_IDLE:
            begin
                if (in_accept && start_product)
                begin
                    state_next = mm_pkg::ST_READ;
                end
            end
            mm_pkg::ST_READ:   state_next = mm_pkg::ST_MUL_LO;
            mm_pkg::ST_MUL_LO: state_next = mm_pkg::ST_MUL_HI;
            mm_pkg::ST_MUL_HI: state_next = mm_pkg::ST_ADD_HI;
            mm_pkg::ST_ADD_HI:
            begin
                state_next = (k_reg == n_last) ? mm_pkg::ST_ROUND : mm_pkg::ST_READ;
            end
            mm_pkg::ST_ROUND:  state_next = mm_pkg::ST_EMIT;
            mm_pkg::ST_EMIT:
            begin
                if (emit_ok)
                begin
                    state_next = last_elem ? mm_pkg::ST_IDLE : mm_pkg::ST_READ;
                end
            end
            default: state_next = mm_pkg::ST_IDLE;
        endcase
    end

    // Datapath and output register.
    always_comb
    begin
        i_next           = i_reg;
        j_next           = j_reg;
        k_next           = k_reg;
        acc_next         = acc_reg;
        prod_next        = prod_reg;
        out_valid_next   = out_valid_reg && out_stall;
        out_row_next     = out_row_reg;
        out_col_next     = out_col_reg;
        out_value_next   = out_value_reg;
        saturated_next   = saturated_reg;
        last_result_next = last_result_reg;
        case (state_reg)
            mm_pkg::ST_IDLE:
            begin
                if (in_accept && start_product)
                begin
                    i_next   = '0;
                    j_next   = '0;
                    k_next   = '0;
                    acc_next = '0;
                end
            end
            mm_pkg::ST_MUL_LO:
            begin
                prod_next = mul_res;
            end
            mm_pkg::ST_MUL_HI:
            begin
                acc_next  = acc_sum;
                prod_next = mul_res;
            end
            mm_pkg::ST_ADD_HI:
            begin
                acc_next = acc_sum;
                if (k_reg != n_last)
                begin
                    k_next = k_reg + 1'b1;
                end
            end
            mm_pkg::ST_ROUND:
            begin
                acc_next = acc_sum;
            end
            mm_pkg::ST_EMIT:
            begin
                if (emit_ok)
                begin
                    out_valid_next   = 1'b1;
                    out_row_next     = mm_pkg::POS_W'(i_reg);
                    out_col_next     = mm_pkg::POS_W'(j_reg);
                    out_value_next   = mm_pkg::WORD_W'(res_val);
                    saturated_next   = !fits;
                    last_result_next = last_elem;
                    acc_next         = '0;
                    k_next           = '0;
                    if (j_reg == o_last)
                    begin
                        j_next = '0;
                        if (i_reg != m_last)
                        begin
                            i_next = i_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        j_next = j_reg + 1'b1;
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= mm_pkg::ST_IDLE;
            i_reg         <= '0;
            j_reg         <= '0;
            k_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            i_reg         <= i_next;
            j_reg         <= j_next;
            k_reg         <= k_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg         <= acc_next;
        prod_reg        <= prod_next;
        out_row_reg     <= out_row_next;
        out_col_reg     <= out_col_next;
        out_value_reg   <= out_value_next;
        saturated_reg   <= saturated_next;
        last_result_reg <= last_result_next;
    end

    assign out_valid   = out_valid_reg;
    assign out_row     = out_row_reg;
    assign out_col     = out_col_reg;
    assign out_value   = out_value_reg;
    assign saturated   = saturated_reg;
    assign last_result = last_result_reg;

    // A new product word only appears out of the emit state.
    a_word_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !$past(out_valid && out_stall)) |-> ($past(state_reg) == mm_pkg::ST_EMIT))
        else $error("product word issued outside the emit state");

    // The final word of a product sits at the last row and column.
    a_last_position: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && last_result) |->
            (out_row == mm_pkg::POS_W'(m_last)) && (out_col == mm_pkg::POS_W'(o_last)))
        else $error("last_result flagged away from the final element");

    // Loop counters stay inside the configured dimensions while a product runs.
    a_counters_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != mm_pkg::ST_IDLE) |->
            (i_reg <= m_last) && (j_reg <= o_last) && (k_reg <= n_last))
        else $error("loop counter beyond configured dimension");

    // Leaving the emit state for idle happens only on the final element.
    a_idle_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        ($past(state_reg) == mm_pkg::ST_EMIT && state_reg == mm_pkg::ST_IDLE) |->
            (out_valid && last_result))
        else $error("product ended without its last word");

endmodule
